/* hdl/sh4ie_pkg.sv */
// Types and opcode constants for the SH-4 integer execute unit.
// No dependencies.
package sh4ie_pkg;

    typedef struct packed {
        logic        req_type;
        logic [15:0] instr_word;
        logic [3:0]  load_index;
        logic [31:0] load_value;
    } t_req;

    typedef struct packed {
        logic [31:0] dest_value;
        logic        t_out;
        logic [31:0] mac_low_out;
        logic [31:0] mac_high_out;
        logic        unsupported;
    } t_res;

    // whole instruction words
    localparam logic [15:0] W_CLRT  = 16'h0008;
    localparam logic [15:0] W_SETT  = 16'h0018;
    localparam logic [15:0] W_CLRS  = 16'h0048;
    localparam logic [15:0] W_SETS  = 16'h0058;
    localparam logic [15:0] W_DIV0U = 16'h0019;
    localparam logic [7:0]  HI_CMPEQ_IMM = 8'h88;
    localparam logic [7:0]  HI_TST_IMM   = 8'hC8;
    localparam logic [7:0]  LO_MOVT      = 8'h29;
    localparam logic [3:0]  HI_MOVT      = 4'h0;

    // key = {instr[15:12], instr[3:0]}
    localparam logic [7:0] K_MULL  = 8'h07;
    localparam logic [7:0] K_DIV0S = 8'h27;
    localparam logic [7:0] K_TST   = 8'h28;
    localparam logic [7:0] K_CMPSTR= 8'h2C;
    localparam logic [7:0] K_XTRCT = 8'h2D;
    localparam logic [7:0] K_MULUW = 8'h2E;
    localparam logic [7:0] K_MULSW = 8'h2F;
    localparam logic [7:0] K_CMPEQ = 8'h30;
    localparam logic [7:0] K_CMPHS = 8'h32;
    localparam logic [7:0] K_CMPGE = 8'h33;
    localparam logic [7:0] K_DIV1  = 8'h34;
    localparam logic [7:0] K_DMULU = 8'h35;
    localparam logic [7:0] K_CMPHI = 8'h36;
    localparam logic [7:0] K_CMPGT = 8'h37;
    localparam logic [7:0] K_SUBC  = 8'h3A;
    localparam logic [7:0] K_SUBV  = 8'h3B;
    localparam logic [7:0] K_DMULS = 8'h3D;
    localparam logic [7:0] K_ADDC  = 8'h3E;
    localparam logic [7:0] K_ADDV  = 8'h3F;
    localparam logic [7:0] K_SHAD  = 8'h4C;
    localparam logic [7:0] K_SHLD  = 8'h4D;
    localparam logic [7:0] K_NEGC  = 8'h6A;
    localparam logic [7:0] K_SWAPB = 8'h68;
    localparam logic [7:0] K_SWAPW = 8'h69;
    localparam logic [7:0] K_EXTUB = 8'h6C;
    localparam logic [7:0] K_EXTUW = 8'h6D;
    localparam logic [7:0] K_EXTSB = 8'h6E;
    localparam logic [7:0] K_EXTSW = 8'h6F;

    // group 4 low bytes
    localparam logic [3:0] HI_GRP4 = 4'h4;
    localparam logic [7:0] L_DT    = 8'h10;
    localparam logic [7:0] L_CMPPZ = 8'h11;
    localparam logic [7:0] L_CMPPL = 8'h15;
    localparam logic [7:0] L_SHLL  = 8'h00;
    localparam logic [7:0] L_SHAL  = 8'h20;
    localparam logic [7:0] L_SHLR  = 8'h01;
    localparam logic [7:0] L_SHAR  = 8'h21;
    localparam logic [7:0] L_ROTL  = 8'h04;
    localparam logic [7:0] L_ROTR  = 8'h05;
    localparam logic [7:0] L_ROTCL = 8'h24;
    localparam logic [7:0] L_ROTCR = 8'h25;

endpackage

/* hdl/sh4ie_stream_if.sv */
// Valid/ready channel carrying one word of type T.
// Used with sh4ie_pkg payload types.
interface sh4ie_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sh4_integer_execute_unit_core.sv */
// SH-4 integer execute unit: one instruction or register load per word.
// Each accepted word passes through the operand register, then the result register.
// Throughput: one word per cycle while the output is not stalled; the register file is read when a word is
// accepted and written when it executes, with a bypass covering the overlap.
// Reset (synchronous, i_rst_n low): GPRs, T, Q, M, S, MACH and MACL all zero.
// Depends on sh4ie_pkg and sh4ie_stream_if.
module sh4_integer_execute_unit_core
    import sh4ie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    sh4ie_stream_if.sink             i_req,
    sh4ie_stream_if.source           o_res
);

    // ---------------- architectural state ----------------
    logic [31:0] r_gpr [16];          // register file, registered read ports
    logic        r_t, r_q, r_m, r_s;
    logic [31:0] r_macl, r_mach;

    // ---------------- operand stage ----------------
    logic        r_in_valid;
    t_req        r_in;
    logic [31:0] r_rd_a, r_rd_b;      // raw memory reads (Rn or R0, Rm)
    logic        r_fwd_a, r_fwd_b;    // bypass from the word retiring at accept
    logic [31:0] r_fwd_data;

    // ---------------- result stage ----------------
    logic        r_out_valid;
    t_res        r_out;

    logic        advance, accept, exe;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [31:0] wr_data;

    // output side frees up or is empty; operand stage then moves on
    assign advance = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || advance;
    assign accept = i_req.valid && i_req.ready;
    assign exe = r_in_valid && advance;

    // read addresses: immediate compares against R0 use port A for R0
    logic [15:0] iw;
    logic [3:0]  addr_a, addr_b;
    assign iw = i_req.data.instr_word;
    assign addr_a = (iw[15:8] == HI_CMPEQ_IMM || iw[15:8] == HI_TST_IMM) ? 4'd0 : iw[11:8];
    assign addr_b = iw[7:4];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in       <= i_req.data;
            r_rd_a     <= r_gpr[addr_a];
            r_rd_b     <= r_gpr[addr_b];
            r_fwd_a    <= wr_en && (wr_idx == addr_a);
            r_fwd_b    <= wr_en && (wr_idx == addr_b);
            r_fwd_data <= wr_data;
        end
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_gpr[i] <= 32'd0;
            end
        end else if (wr_en) begin
            r_gpr[wr_idx] <= wr_data;
        end
    end

    // ---------------- execute ----------------
    logic [31:0] rn, rm;
    logic [15:0] w;
    logic [7:0]  key;
    assign rn  = r_fwd_a ? r_fwd_data : r_rd_a;
    assign rm  = r_fwd_b ? r_fwd_data : r_rd_b;
    assign w   = r_in.instr_word;
    assign key = {w[15:12], w[3:0]};

    // shared 33x33 signed multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    always_comb begin
        case (key)
            K_DMULS: begin
                mul_a = {rn[31], rn};
                mul_b = {rm[31], rm};
            end
            K_MULSW: begin
                mul_a = {{17{rn[15]}}, rn[15:0]};
                mul_b = {{17{rm[15]}}, rm[15:0]};
            end
            K_MULUW: begin
                mul_a = {17'd0, rn[15:0]};
                mul_b = {17'd0, rm[15:0]};
            end
            default: begin
                mul_a = {1'b0, rn};
                mul_b = {1'b0, rm};
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    logic        ok, wr, t_n, q_n, m_n, s_n;
    logic [1:0]  dmode;               // 0 Rn after, 1 R0, 2 zero
    logic [31:0] res, macl_n, mach_n, x;
    logic [32:0] sum;
    logic [4:0]  sh_amt;
    logic        cy;

    always_comb begin
        ok = 1'b1; wr = 1'b0; res = rn; dmode = 2'd0;
        t_n = r_t; q_n = r_q; m_n = r_m; s_n = r_s;
        macl_n = r_macl; mach_n = r_mach;
        x = rn ^ rm; sum = 33'd0; cy = 1'b0;
        sh_amt = ~rm[4:0] + 5'd1;
        if (w == W_CLRT) begin
            t_n = 1'b0; dmode = 2'd2;
        end else if (w == W_SETT) begin
            t_n = 1'b1; dmode = 2'd2;
        end else if (w == W_CLRS) begin
            s_n = 1'b0; dmode = 2'd2;
        end else if (w == W_SETS) begin
            s_n = 1'b1; dmode = 2'd2;
        end else if (w == W_DIV0U) begin
            q_n = 1'b0; m_n = 1'b0; t_n = 1'b0; dmode = 2'd2;
        end else if (w[15:8] == HI_CMPEQ_IMM) begin
            t_n = (rn == {{24{w[7]}}, w[7:0]}); dmode = 2'd1;
        end else if (w[15:8] == HI_TST_IMM) begin
            t_n = ((rn[7:0] & w[7:0]) == 8'd0); dmode = 2'd1;
        end else if (w[15:12] == HI_MOVT && w[7:0] == LO_MOVT) begin
            res = {31'd0, r_t}; wr = 1'b1;
        end else begin
            case (key)
                K_MULL, K_MULUW, K_MULSW: macl_n = prod[31:0];
                K_DMULU, K_DMULS: begin
                    macl_n = prod[31:0]; mach_n = prod[63:32];
                end
                K_DIV0S: begin
                    q_n = rn[31]; m_n = rm[31]; t_n = rn[31] ^ rm[31];
                end
                K_TST:   t_n = ((rn & rm) == 32'd0);
                K_CMPSTR: t_n = (x[7:0] == 8'd0) || (x[15:8] == 8'd0) ||
                                (x[23:16] == 8'd0) || (x[31:24] == 8'd0);
                K_XTRCT: begin res = {rm[15:0], rn[31:16]}; wr = 1'b1; end
                K_CMPEQ: t_n = (rn == rm);
                K_CMPHS: t_n = (rn >= rm);
                K_CMPGE: t_n = ($signed(rn) >= $signed(rm));
                K_CMPHI: t_n = (rn > rm);
                K_CMPGT: t_n = ($signed(rn) > $signed(rm));
                K_DIV1: begin
                    // add or subtract divisor per Q==M; cy is carry or borrow
                    if (r_q == r_m) sum = {1'b0, rn[30:0], r_t} - {1'b0, rm};
                    else            sum = {1'b0, rn[30:0], r_t} + {1'b0, rm};
                    cy  = sum[32];
                    res = sum[31:0];
                    q_n = rn[31] ^ cy ^ r_m;
                    t_n = (q_n == r_m);
                    wr  = 1'b1;
                end
                K_SUBC: begin
                    sum = {1'b0, rn} - {1'b0, rm} - {32'd0, r_t};
                    res = sum[31:0]; t_n = sum[32]; wr = 1'b1;
                end
                K_SUBV: begin
                    res = rn - rm; t_n = x[31] & (rn[31] ^ res[31]); wr = 1'b1;
                end
                K_ADDC: begin
                    sum = {1'b0, rn} + {1'b0, rm} + {32'd0, r_t};
                    res = sum[31:0]; t_n = sum[32]; wr = 1'b1;
                end
                K_ADDV: begin
                    res = rn + rm; t_n = ~x[31] & (rn[31] ^ res[31]); wr = 1'b1;
                end
                K_SHAD, K_SHLD: begin
                    wr = 1'b1;
                    if (!rm[31])             res = rn << rm[4:0];
                    else if (rm[4:0] == 5'd0) res = (w[0] || !rn[31]) ? 32'd0 : 32'hFFFF_FFFF;
                    else if (w[0])           res = rn >> sh_amt;
                    else                     res = $unsigned($signed(rn) >>> sh_amt);
                end
                K_NEGC: begin
                    sum = 33'd0 - {1'b0, rm} - {32'd0, r_t};
                    res = sum[31:0]; t_n = sum[32]; wr = 1'b1;
                end
                K_SWAPB: begin res = {rm[31:16], rm[7:0], rm[15:8]}; wr = 1'b1; end
                K_SWAPW: begin res = {rm[15:0], rm[31:16]}; wr = 1'b1; end
                K_EXTUB: begin res = {24'd0, rm[7:0]}; wr = 1'b1; end
                K_EXTUW: begin res = {16'd0, rm[15:0]}; wr = 1'b1; end
                K_EXTSB: begin res = {{24{rm[7]}}, rm[7:0]}; wr = 1'b1; end
                K_EXTSW: begin res = {{16{rm[15]}}, rm[15:0]}; wr = 1'b1; end
                default: begin
                    ok = (w[15:12] == HI_GRP4);
                    case (w[7:0])
                        L_DT: begin
                            res = rn - 32'd1; t_n = (res == 32'd0); wr = 1'b1;
                        end
                        L_CMPPZ: t_n = !rn[31];
                        L_CMPPL: t_n = !rn[31] && (rn != 32'd0);
                        L_SHLL, L_SHAL: begin
                            t_n = rn[31]; res = {rn[30:0], 1'b0}; wr = 1'b1;
                        end
                        L_SHLR: begin t_n = rn[0]; res = {1'b0, rn[31:1]}; wr = 1'b1; end
                        L_SHAR: begin t_n = rn[0]; res = {rn[31], rn[31:1]}; wr = 1'b1; end
                        L_ROTL: begin t_n = rn[31]; res = {rn[30:0], rn[31]}; wr = 1'b1; end
                        L_ROTR: begin t_n = rn[0]; res = {rn[0], rn[31:1]}; wr = 1'b1; end
                        L_ROTCL: begin t_n = rn[31]; res = {rn[30:0], r_t}; wr = 1'b1; end
                        L_ROTCR: begin t_n = rn[0]; res = {r_t, rn[31:1]}; wr = 1'b1; end
                        default: ok = 1'b0;
                    endcase
                end
            endcase
        end
    end

    // register file write port: direct load or instruction writeback
    assign wr_en   = exe && (r_in.req_type || (ok && wr));
    assign wr_idx  = r_in.req_type ? r_in.load_index : w[11:8];
    assign wr_data = r_in.req_type ? r_in.load_value : res;

    // result word assembled from post-step state
    t_res res_word;
    always_comb begin
        res_word.t_out        = r_t;
        res_word.mac_low_out  = r_macl;
        res_word.mac_high_out = r_mach;
        res_word.unsupported  = 1'b0;
        res_word.dest_value   = 32'd0;
        if (r_in.req_type) begin
            res_word.dest_value = r_in.load_value;
        end else if (!ok) begin
            res_word.unsupported = 1'b1;
        end else begin
            res_word.t_out        = t_n;
            res_word.mac_low_out  = macl_n;
            res_word.mac_high_out = mach_n;
            case (dmode)
                2'd0:    res_word.dest_value = wr ? res : rn;
                2'd1:    res_word.dest_value = rn;
                default: res_word.dest_value = 32'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_t <= 1'b0; r_q <= 1'b0; r_m <= 1'b0; r_s <= 1'b0;
            r_macl <= 32'd0; r_mach <= 32'd0;
        end else begin
            if (accept)       r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance)      r_out_valid <= r_in_valid;
            if (exe && !r_in.req_type && ok) begin
                r_t <= t_n; r_q <= q_n; r_m <= m_n; r_s <= s_n;
                r_macl <= macl_n; r_mach <= mach_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exe) begin
            r_out <= res_word;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule
